FILE: src/matrix3_inverse_unit_defines.svh
// Assertion macros shared by the 3x3 matrix inverse unit.
`ifndef MATRIX3_INVERSE_UNIT_DEFINES_SVH
`define MATRIX3_INVERSE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define M3I_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define M3I_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/m3i_pkg.sv
// Shared widths, types and the cofactor selection table of the 3x3 inverse unit.
package m3i_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int N_ENT     = 9;

  localparam int PROD_W   = 2 * WORD_BITS;
  localparam int COF_W    = PROD_W + 1;
  localparam int DET_W    = WORD_BITS + COF_W + 2;
  localparam int Q_BITS   = WORD_BITS + 1;
  localparam int NUM_W    = COF_W + 2 * FRAC_BITS;
  localparam int REM_W    = DET_W;
  localparam int DATA_W   = N_ENT * WORD_BITS;
  localparam int CD_LAT   = 4;
  localparam int LANE_LAT = Q_BITS + 2;
  localparam int LAT      = CD_LAT + LANE_LAT + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef word_t [N_ENT-1:0]           mat_t;
  typedef logic signed [COF_W-1:0]     cof_t;
  typedef cof_t [N_ENT-1:0]            cofv_t;
  typedef logic signed [DET_W-1:0]     det_t;

  // Each cofactor is a*b - c*d over these row-major entry indexes.
  localparam int unsigned COF_SEL [N_ENT][4] = '{
    '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
    '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
    '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
  };

endpackage

FILE: src/m3i_cofdet.sv
// Pipelined cofactor and determinant datapath of the 3x3 inverse unit.
module m3i_cofdet (
  input  logic           clk,
  input  logic           en,
  input  m3i_pkg::mat_t  m,
  output m3i_pkg::cofv_t cof,
  output m3i_pkg::det_t  det
);
  import m3i_pkg::*;

  logic signed [PROD_W-1:0] pp_r   [2*N_ENT];
  word_t                    row1_r [3];
  word_t                    row2_r [3];
  cof_t                     cof2_r [N_ENT];
  cof_t                     cof3_r [N_ENT];
  cof_t                     cof4_r [N_ENT];
  logic signed [COF_W-1:0]  lo_r   [3];
  logic signed [COF_W-1:0]  hi_r   [3];
  det_t                     term   [3];
  det_t                     det_r;

  // The first-row products are split so that no multiplier exceeds 32 by 33 bits.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      term[j] = (det_t'(hi_r[j]) <<< WORD_BITS) + det_t'(lo_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N_ENT; k++) begin
        pp_r[2*k]   <= PROD_W'($signed(m[COF_SEL[k][0]]) * $signed(m[COF_SEL[k][1]]));
        pp_r[2*k+1] <= PROD_W'($signed(m[COF_SEL[k][2]]) * $signed(m[COF_SEL[k][3]]));
        cof2_r[k]   <= $signed({pp_r[2*k][PROD_W-1], pp_r[2*k]})
                     - $signed({pp_r[2*k+1][PROD_W-1], pp_r[2*k+1]});
        cof3_r[k]   <= cof2_r[k];
        cof4_r[k]   <= cof3_r[k];
      end
      for (int j = 0; j < 3; j++) begin
        row1_r[j] <= m[j];
        row2_r[j] <= row1_r[j];
        lo_r[j]   <= $signed(row2_r[j]) * $signed({1'b0, cof2_r[j][WORD_BITS-1:0]});
        hi_r[j]   <= $signed(row2_r[j]) * $signed(cof2_r[j][COF_W-1:WORD_BITS]);
      end
      det_r <= term[0] + term[1] + term[2];
    end
  end

  always_comb begin
    for (int k = 0; k < N_ENT; k++) begin
      cof[k] = cof4_r[k];
    end
  end
  assign det = det_r;

endmodule

FILE: src/m3i_lane.sv
// One division lane: cofactor scaled by 2^(2*FRAC_BITS) over the determinant, saturated.
module m3i_lane (
  input  logic          clk,
  input  logic          en,
  input  m3i_pkg::cof_t cof,
  input  m3i_pkg::det_t det,
  output m3i_pkg::word_t res,
  output logic          ovf
);
  import m3i_pkg::*;

  logic [COF_W-1:0]  cmag;
  logic [DET_W-1:0]  dmag;
  logic [NUM_W-1:0]  num;
  logic [REM_W-1:0]  rem0;

  logic [REM_W-1:0]  rem_r  [Q_BITS+1];
  logic [REM_W-1:0]  dmag_r [Q_BITS+1];
  logic [Q_BITS-1:0] q_r    [Q_BITS+1];
  logic [Q_BITS-1:0] nlo_r  [Q_BITS+1];
  logic              neg_r  [Q_BITS+1];
  logic              big_r  [Q_BITS+1];

  logic [REM_W-1:0]  t      [Q_BITS];
  logic              ge     [Q_BITS];

  logic [Q_BITS-1:0] q;
  logic [Q_BITS-1:0] pos_lim;
  logic [Q_BITS-1:0] neg_lim;
  word_t             res_nxt;
  logic              ovf_nxt;
  word_t             res_r;
  logic              ovf_r;

  assign cmag = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
  assign dmag = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
  assign num  = {cmag, {(2*FRAC_BITS){1'b0}}};
  assign rem0 = REM_W'(num[NUM_W-1:Q_BITS]);

  // One restoring step per stage, most significant quotient bit first.
  always_comb begin
    for (int g = 0; g < Q_BITS; g++) begin
      t[g]  = {rem_r[g][REM_W-2:0], nlo_r[g][Q_BITS-1-g]};
      ge[g] = (t[g] >= dmag_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= rem0;
      dmag_r[0] <= REM_W'(dmag);
      q_r[0]    <= '0;
      nlo_r[0]  <= num[Q_BITS-1:0];
      neg_r[0]  <= cof[COF_W-1] ^ det[DET_W-1];
      // A quotient of 2^Q_BITS or more saturates in every case.
      big_r[0]  <= (rem0 >= REM_W'(dmag));
      for (int g = 0; g < Q_BITS; g++) begin
        rem_r[g+1]  <= ge[g] ? (t[g] - dmag_r[g]) : t[g];
        dmag_r[g+1] <= dmag_r[g];
        q_r[g+1]    <= {q_r[g][Q_BITS-2:0], ge[g]};
        nlo_r[g+1]  <= nlo_r[g];
        neg_r[g+1]  <= neg_r[g];
        big_r[g+1]  <= big_r[g];
      end
      res_r <= res_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign q       = q_r[Q_BITS];
  assign pos_lim = {2'b00, {(WORD_BITS-1){1'b1}}};
  assign neg_lim = {2'b01, {(WORD_BITS-1){1'b0}}};

  always_comb begin
    res_nxt = q[WORD_BITS-1:0];
    ovf_nxt = 1'b0;
    if (!neg_r[Q_BITS]) begin
      if (big_r[Q_BITS] || (q > pos_lim)) begin
        res_nxt = {1'b0, {(WORD_BITS-1){1'b1}}};
        ovf_nxt = 1'b1;
      end
    end else begin
      if (big_r[Q_BITS] || (q > neg_lim)) begin
        res_nxt = {1'b1, {(WORD_BITS-1){1'b0}}};
        ovf_nxt = 1'b1;
      end else begin
        res_nxt = -q[WORD_BITS-1:0];
      end
    end
  end

  assign res = res_r;
  assign ovf = ovf_r;

endmodule

FILE: src/matrix3_inverse_unit.sv
// Top level of the 3x3 fixed-point matrix inverse unit.
// Usage:
// The input stream carries one 3x3 matrix per request on in_tdata: nine signed
// Q16.16 entries in row-major order, entry a00 in the lowest bits. The output
// stream returns one request per matrix: the nine inverse entries in the same
// layout, with out_tuser holding the singular flag (bit 0) and overflow (bit 1).
// A singular matrix is returned unchanged with singular set.
// Throughput is one matrix per clock cycle unless the receiver stalls. The
// path from acceptance to out_tvalid holds registers for products, cofactors
// and determinant, one quotient bit per stage for 33 stages in each of nine
// parallel division lanes, and three registers for lane setup, saturation and
// the merged output. When the receiver stalls, the whole pipeline holds and
// in_tready drops in the same cycle; nothing is lost. Reset empties the
// pipeline; the unit holds no other state.
module matrix3_inverse_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [m3i_pkg::DATA_W-1:0]  in_tdata,   // a00, a01, a02, a10, ..., a22
  input  logic                        in_tvalid,
  output logic                        in_tready,
  output logic [m3i_pkg::DATA_W-1:0]  out_tdata,  // r00, r01, r02, r10, ..., r22
  output logic [1:0]                  out_tuser,  // singular, overflow
  output logic                        out_tvalid,
  input  logic                        out_tready
);
  import m3i_pkg::*;
  `include "matrix3_inverse_unit_defines.svh"

  logic              en;
  cofv_t             cofv;
  det_t              det;
  mat_t              res_v;
  logic [N_ENT-1:0]  ovf_v;

  logic              vld_r  [LAT];
  logic [DATA_W-1:0] echo_r [LAT-1];
  logic              dz_r   [LANE_LAT];
  logic [DATA_W-1:0] data_r;
  logic              sing_r;
  logic              ovf_r;
  logic              sat_seen;

  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  m3i_cofdet u_cofdet (
    .clk (clk),
    .en  (en),
    .m   (mat_t'(in_tdata)),
    .cof (cofv),
    .det (det)
  );

  // Lane k produces inverse entry (row k/3, column k%3) from the transposed cofactor.
  for (genvar k = 0; k < N_ENT; k++) begin : g_lane
    m3i_lane u_lane (
      .clk (clk),
      .en  (en),
      .cof (cofv[(k % 3) * 3 + k / 3]),
      .det (det),
      .res (res_v[k]),
      .ovf (ovf_v[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      echo_r[0] <= in_tdata;
      for (int i = 1; i < LAT - 1; i++) begin
        echo_r[i] <= echo_r[i-1];
      end
      dz_r[0] <= (det == '0);
      for (int i = 1; i < LANE_LAT; i++) begin
        dz_r[i] <= dz_r[i-1];
      end
      data_r <= dz_r[LANE_LAT-1] ? echo_r[LAT-2] : DATA_W'(res_v);
      sing_r <= dz_r[LANE_LAT-1];
      ovf_r  <= !dz_r[LANE_LAT-1] && (|ovf_v);
    end
  end

  assign out_tdata  = data_r;
  assign out_tuser  = {ovf_r, sing_r};
  assign out_tvalid = vld_r[LAT-1];

  always_comb begin
    sat_seen = 1'b0;
    for (int k = 0; k < N_ENT; k++) begin
      if (data_r[k*WORD_BITS +: WORD_BITS] == {1'b0, {(WORD_BITS-1){1'b1}}} ||
          data_r[k*WORD_BITS +: WORD_BITS] == {1'b1, {(WORD_BITS-1){1'b0}}}) begin
        sat_seen = 1'b1;
      end
    end
  end

  `M3I_CHK_NOW(a_sing_no_ovf, out_tvalid && out_tuser[0], !out_tuser[1], "singular result with overflow set")
  `M3I_CHK_NOW(a_ovf_has_limit, out_tvalid && out_tuser[1], sat_seen, "overflow set but no entry at a limit")
  `M3I_CHK_NEXT(a_pipe_advance, in_tvalid && in_tready, vld_r[0], "accepted request not tracked in pipeline")

endmodule
